[rtl/core/cpo_pkg.sv]
// Shared types and constants for the collision push-out pipeline.
package cpo_pkg;

   localparam int CoordW = 32;
   localparam int RadW   = 31;
   localparam int RootW  = 32;
   localparam int SqW    = 2 * RootW;
   localparam int DivW   = 32;
   localparam int OffW   = DivW + 1;
   localparam int Lanes  = 3;

   typedef enum logic [1:0] {
      FUNC_SPHERE  = 2'd0,
      FUNC_CYL     = 2'd1,
      FUNC_SPH_CYL = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [CoordW-1:0]   a_x;
      logic [CoordW-1:0]   a_y;
      logic [CoordW-1:0]   a_z;
      logic [RadW-1:0]     a_radius;
      logic [RadW-1:0]     a_height;
      logic [CoordW-1:0]   b_x;
      logic [CoordW-1:0]   b_y;
      logic [CoordW-1:0]   b_z;
      logic [RadW-1:0]     b_radius;
      logic [RadW-1:0]     b_height;
   } cpo_req_type;

   typedef struct packed {
      logic                hit;
      logic                push;
      logic                cyl;
      logic [RootW-1:0]    range;
      logic [RootW-1:0]    mag_x;
      logic [RootW-1:0]    mag_y;
      logic [RootW-1:0]    mag_z;
      logic                neg_x;
      logic                neg_y;
      logic                neg_z;
      logic [CoordW-1:0]   base_x;
      logic [CoordW-1:0]   base_y;
      logic [CoordW-1:0]   base_z;
      logic [CoordW-1:0]   pass_x;
      logic [CoordW-1:0]   pass_y;
      logic [CoordW-1:0]   pass_z;
   } cpo_side_type;

endpackage

[rtl/core/cpo_if.sv]
// Channel interfaces for request and response beats.
interface cpo_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] a_x;
   logic [31:0] a_y;
   logic [31:0] a_z;
   logic [30:0] a_radius;
   logic [30:0] a_height;
   logic [31:0] b_x;
   logic [31:0] b_y;
   logic [31:0] b_z;
   logic [30:0] b_radius;
   logic [30:0] b_height;

   modport source (output valid, func, a_x, a_y, a_z, a_radius, a_height,
                   b_x, b_y, b_z, b_radius, b_height, input ready);
   modport sink (input valid, func, a_x, a_y, a_z, a_radius, a_height,
                 b_x, b_y, b_z, b_radius, b_height, output ready);
endinterface

interface cpo_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [31:0] out_z;

   modport source (output valid, hit, out_x, out_y, out_z, input ready);
   modport sink (input valid, hit, out_x, out_y, out_z, output ready);
endinterface

[rtl/core/cpo_front.sv]
// Front end: differences, range checks, squares and the overlap decision.
module cpo_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cpo_pkg::cpo_req_type  in_req,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [cpo_pkg::SqW-1:0] out_s,
   output cpo_pkg::cpo_side_type out_side
);
   import cpo_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   cpo_req_type r1_ff, r2_ff;
   logic [CoordW:0] m2x_ff, m2y_ff, m2z_ff;
   logic            n2x_ff, n2y_ff, n2z_ff;
   logic [RootW-1:0] rng2_ff;
   logic            vert2_ff;

   logic [SqW-1:0]  sqx3_ff, sqy3_ff, sqz3_ff, rr3_ff;
   logic            ok3_ff, sph3_ff, vert3_ff;
   cpo_side_type    side3_ff;

   logic [SqW-1:0]  s4_ff;
   cpo_side_type    side4_ff;

   // stage 2 inputs
   logic [CoordW:0] dx_in, dy_in, dz_in;
   logic [CoordW:0] mx_in, my_in, mz_in;
   logic [RootW-1:0] rng_in;
   logic            vert_in;

   // stage 3 inputs
   logic            cyl_in, ok_in;
   logic [CoordW:0] myc_in;
   cpo_side_type    side_in;

   // stage 4 inputs
   logic [SqW+1:0]  sum_in, rr_in;
   logic            hit_in;
   cpo_side_type    side4_in;

   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) r1_ff <= in_req;
   end

   always_comb begin
      logic signed [CoordW+1:0] ay, by, ah, bh, ar;
      ay = {{2{r1_ff.a_y[CoordW-1]}}, r1_ff.a_y};
      by = {{2{r1_ff.b_y[CoordW-1]}}, r1_ff.b_y};
      ah = {3'b000, r1_ff.a_height};
      bh = {3'b000, r1_ff.b_height};
      ar = {3'b000, r1_ff.a_radius};
      dx_in = {r1_ff.b_x[CoordW-1], r1_ff.b_x} - {r1_ff.a_x[CoordW-1], r1_ff.a_x};
      dy_in = {r1_ff.b_y[CoordW-1], r1_ff.b_y} - {r1_ff.a_y[CoordW-1], r1_ff.a_y};
      dz_in = {r1_ff.b_z[CoordW-1], r1_ff.b_z} - {r1_ff.a_z[CoordW-1], r1_ff.a_z};
      mx_in = dx_in[CoordW] ? (~dx_in + 1'b1) : dx_in;
      my_in = dy_in[CoordW] ? (~dy_in + 1'b1) : dy_in;
      mz_in = dz_in[CoordW] ? (~dz_in + 1'b1) : dz_in;
      rng_in = {1'b0, r1_ff.a_radius} + {1'b0, r1_ff.b_radius};
      if (r1_ff.func == FUNC_CYL) begin
         vert_in = !(ay > by + bh) && !(ay + ah < by);
      end else begin
         vert_in = !(ay - ar > by + bh) && !(ay + ar < by);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         r2_ff    <= r1_ff;
         m2x_ff   <= mx_in;
         m2y_ff   <= my_in;
         m2z_ff   <= mz_in;
         n2x_ff   <= dx_in[CoordW];
         n2y_ff   <= dy_in[CoordW];
         n2z_ff   <= dz_in[CoordW];
         rng2_ff  <= rng_in;
         vert2_ff <= vert_in;
      end
   end

   // Cylinder tests work in the XZ plane only, so the y component drops out.
   always_comb begin
      cyl_in = r2_ff.func inside {FUNC_CYL, FUNC_SPH_CYL};
      myc_in = cyl_in ? '0 : m2y_ff;
      ok_in  = (m2x_ff <= {1'b0, rng2_ff}) && (myc_in <= {1'b0, rng2_ff})
               && (m2z_ff <= {1'b0, rng2_ff});
      side_in.hit    = 1'b0;
      side_in.push   = 1'b0;
      side_in.cyl    = cyl_in;
      side_in.range  = rng2_ff;
      side_in.mag_x  = m2x_ff[RootW-1:0];
      side_in.mag_y  = myc_in[RootW-1:0];
      side_in.mag_z  = m2z_ff[RootW-1:0];
      side_in.neg_x  = n2x_ff;
      side_in.neg_y  = cyl_in ? 1'b0 : n2y_ff;
      side_in.neg_z  = n2z_ff;
      side_in.base_x = cyl_in ? r2_ff.b_x : r2_ff.a_x;
      side_in.base_y = cyl_in ? r2_ff.b_y : r2_ff.a_y;
      side_in.base_z = cyl_in ? r2_ff.b_z : r2_ff.a_z;
      side_in.pass_x = r2_ff.b_x;
      side_in.pass_y = r2_ff.b_y;
      side_in.pass_z = r2_ff.b_z;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sqx3_ff  <= side_in.mag_x * side_in.mag_x;
         sqy3_ff  <= side_in.mag_y * side_in.mag_y;
         sqz3_ff  <= side_in.mag_z * side_in.mag_z;
         rr3_ff   <= rng2_ff * rng2_ff;
         ok3_ff   <= ok_in;
         sph3_ff  <= (r2_ff.func == FUNC_SPHERE);
         vert3_ff <= vert2_ff;
         side3_ff <= side_in;
      end
   end

   always_comb begin
      sum_in = {2'b00, sqx3_ff} + {2'b00, sqy3_ff} + {2'b00, sqz3_ff};
      rr_in  = {2'b00, rr3_ff};
      if (sph3_ff) begin
         hit_in = ok3_ff && (side3_ff.range != '0) && (sum_in < rr_in);
      end else begin
         hit_in = ok3_ff && side3_ff.cyl && vert3_ff && (sum_in <= rr_in);
      end
      side4_in      = side3_ff;
      side4_in.hit  = hit_in;
      side4_in.push = hit_in && (sum_in != '0);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_ff    <= sum_in[SqW-1:0];
         side4_ff <= side4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_s     = s4_ff;
   assign out_side  = side4_ff;

endmodule

[rtl/core/cpo_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module cpo_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [cpo_pkg::SqW-1:0] in_s,
   input  cpo_pkg::cpo_side_type   in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [cpo_pkg::RootW-1:0] out_root,
   output cpo_pkg::cpo_side_type   out_side
);
   import cpo_pkg::*;

   logic [RootW-1:0]            v_ff;
   logic [RootW:0]              en;
   logic [RootW-1:0][RootW+1:0] rem_ff;
   logic [RootW-1:0][RootW-1:0] root_ff;
   logic [RootW-1:0][SqW-1:0]   s_ff;
   cpo_side_type                side_ff [RootW];

   assign en[RootW] = out_ready;
   assign in_ready  = en[0];

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      logic                pv;
      logic [RootW+1:0]    prem;
      logic [RootW-1:0]    proot;
      logic [SqW-1:0]      ps;
      cpo_side_type        pside;
      logic [RootW+3:0]    trial, test;
      logic                ge;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign ps    = in_s;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign ps    = s_ff[k-1];
         assign pside = side_ff[k-1];
      end

      assign en[k] = !v_ff[k] || en[k+1];
      assign trial = {prem, ps[SqW-1-2*k -: 2]};
      assign test  = {2'b00, proot, 2'b01};
      assign ge    = trial >= test;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= ge ? (RootW+2)'(trial - test) : trial[RootW+1:0];
            root_ff[k] <= {proot[RootW-2:0], ge};
            s_ff[k]    <= ps;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = v_ff[RootW-1];
   assign out_root  = root_ff[RootW-1];
   assign out_side  = side_ff[RootW-1];

endmodule

[rtl/core/cpo_div.sv]
// Offset scaling: product, pipelined three-lane divide and round to nearest.
module cpo_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [cpo_pkg::RootW-1:0] in_root,
   input  cpo_pkg::cpo_side_type     in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [cpo_pkg::Lanes-1:0][cpo_pkg::OffW-1:0] out_off,
   output cpo_pkg::cpo_side_type     out_side
);
   import cpo_pkg::*;

   logic                         vm_ff, vr_ff;
   logic                         en_m, en_r;
   logic [DivW-1:0]              vd_ff;
   logic [DivW:0]                en_d;

   logic [Lanes-1:0][2*DivW-1:0] num_m_ff;
   logic [DivW-1:0]              den_m_ff;
   cpo_side_type                 side_m_ff;

   logic [DivW-1:0][Lanes-1:0][DivW-1:0] rem_ff;
   logic [DivW-1:0][Lanes-1:0][DivW-1:0] q_ff;
   logic [DivW-1:0][Lanes-1:0][DivW-1:0] low_ff;
   logic [DivW-1:0][DivW-1:0]            den_ff;
   cpo_side_type                         side_ff [DivW];

   logic [Lanes-1:0][OffW-1:0]   off_r_ff;
   cpo_side_type                 side_r_ff;

   logic [DivW-1:0]              f_in;
   logic [Lanes-1:0][DivW-1:0]   mag_in;

   assign en_r         = !vr_ff || out_ready;
   assign en_d[DivW]   = en_r;
   assign en_m         = !vm_ff || en_d[0];
   assign in_ready     = en_m;

   // Sphere pairs scale by the radius sum, cylinders by the shortfall.
   always_comb begin
      f_in      = in_side.cyl ? (in_side.range - in_root) : in_side.range;
      mag_in[0] = in_side.mag_x;
      mag_in[1] = in_side.mag_y;
      mag_in[2] = in_side.mag_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
         vr_ff <= 1'b0;
      end else begin
         if (en_m) vm_ff <= in_valid;
         if (en_r) vr_ff <= vd_ff[DivW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_m) begin
         for (int j = 0; j < Lanes; j++) begin
            num_m_ff[j] <= mag_in[j] * f_in;
         end
         den_m_ff  <= in_root;
         side_m_ff <= in_side;
      end
   end

   for (genvar k = 0; k < DivW; k++) begin : g_stage
      logic                       pv;
      logic [Lanes-1:0][DivW-1:0] prem, pq, plow;
      logic [DivW-1:0]            pden;
      cpo_side_type               pside;
      logic [Lanes-1:0][DivW:0]   t;
      logic [Lanes-1:0]           ge;

      if (k == 0) begin : g_first
         assign pv    = vm_ff;
         assign pden  = den_m_ff;
         assign pside = side_m_ff;
         for (genvar j = 0; j < Lanes; j++) begin : g_lane
            assign prem[j] = num_m_ff[j][2*DivW-1:DivW];
            assign plow[j] = num_m_ff[j][DivW-1:0];
            assign pq[j]   = '0;
         end
      end else begin : g_next
         assign pv    = vd_ff[k-1];
         assign pden  = den_ff[k-1];
         assign pside = side_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign plow  = low_ff[k-1];
         assign pq    = q_ff[k-1];
      end

      assign en_d[k] = !vd_ff[k] || en_d[k+1];

      always_comb begin
         for (int j = 0; j < Lanes; j++) begin
            t[j]  = {prem[j], plow[j][DivW-1-k]};
            ge[j] = t[j] >= {1'b0, pden};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (en_d[k]) begin
            vd_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en_d[k]) begin
            for (int j = 0; j < Lanes; j++) begin
               rem_ff[k][j] <= ge[j] ? DivW'(t[j] - {1'b0, pden}) : t[j][DivW-1:0];
               q_ff[k][j]   <= {pq[j][DivW-2:0], ge[j]};
            end
            low_ff[k]  <= plow;
            den_ff[k]  <= pden;
            side_ff[k] <= pside;
         end
      end
   end

   // Round half away from zero on the magnitude: bump when 2r >= den.
   always_ff @(posedge clock) begin
      if (en_r) begin
         for (int j = 0; j < Lanes; j++) begin
            off_r_ff[j] <= {1'b0, q_ff[DivW-1][j]}
                           + OffW'({rem_ff[DivW-1][j], 1'b0} >= {1'b0, den_ff[DivW-1]});
         end
         side_r_ff <= side_ff[DivW-1];
      end
   end

   assign out_valid = vr_ff;
   assign out_off   = off_r_ff;
   assign out_side  = side_r_ff;

endmodule

[rtl/core/collision_pushout_top.sv]
// Top level of the sphere and cylinder collision push-out pipeline.
//
//   channel   dir   beat contents
//   req_if    in    func, body A and body B position, radius, height
//   rsp_if    out   hit, out_x, out_y, out_z
//
// One beat enters per cycle unless a stalled response holds the pipeline.
// Each result passes through the 32-stage square root and the 32-stage divider.
// Reset empties every stage; no data is held across reset.
// Every stage has its own valid bit, so a stalled response lets earlier
// empty stages fill up and nothing is dropped or repeated.
module collision_pushout_top (
   input  logic      clock,
   input  logic      reset,
   cpo_req_if.sink   req_if,
   cpo_rsp_if.source rsp_if
);
   import cpo_pkg::*;

   cpo_req_type  req;
   logic         fr_valid, fr_ready;
   logic [SqW-1:0] fr_s;
   cpo_side_type fr_side;
   logic         sq_valid, sq_ready;
   logic [RootW-1:0] sq_root;
   cpo_side_type sq_side;
   logic         dv_valid, dv_ready;
   logic [Lanes-1:0][OffW-1:0] dv_off;
   cpo_side_type dv_side;

   logic         ov_ff;
   logic         hit_ff;
   logic [Lanes-1:0][CoordW-1:0] pos_ff;
   logic [Lanes-1:0][CoordW-1:0] pos_in;

   function automatic logic [CoordW-1:0] sat_coord(input logic [CoordW+1:0] v);
      logic [CoordW-1:0] r;
      if (v[CoordW+1:CoordW-1] == 3'b000 || v[CoordW+1:CoordW-1] == 3'b111) begin
         r = v[CoordW-1:0];
      end else if (v[CoordW+1]) begin
         r = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CoordW-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      req.func     = func_type'(req_if.func);
      req.a_x      = req_if.a_x;
      req.a_y      = req_if.a_y;
      req.a_z      = req_if.a_z;
      req.a_radius = req_if.a_radius;
      req.a_height = req_if.a_height;
      req.b_x      = req_if.b_x;
      req.b_y      = req_if.b_y;
      req.b_z      = req_if.b_z;
      req.b_radius = req_if.b_radius;
      req.b_height = req_if.b_height;
   end

   cpo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_req    (req),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_s     (fr_s),
      .out_side  (fr_side)
   );

   cpo_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_s      (fr_s),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   cpo_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_off   (dv_off),
      .out_side  (dv_side)
   );

   assign dv_ready = !ov_ff || rsp_if.ready;

   always_comb begin
      logic [Lanes-1:0][CoordW-1:0] base, pass;
      logic [Lanes-1:0]             neg;
      logic [CoordW+1:0]            b_ext, o_ext, sum;
      base = {dv_side.base_z, dv_side.base_y, dv_side.base_x};
      pass = {dv_side.pass_z, dv_side.pass_y, dv_side.pass_x};
      neg  = {dv_side.neg_z, dv_side.neg_y, dv_side.neg_x};
      for (int j = 0; j < Lanes; j++) begin
         b_ext = {{2{base[j][CoordW-1]}}, base[j]};
         o_ext = {1'b0, dv_off[j]};
         sum   = neg[j] ? (b_ext - o_ext) : (b_ext + o_ext);
         pos_in[j] = (dv_side.hit && dv_side.push) ? sat_coord(sum) : pass[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (dv_ready) begin
         ov_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dv_ready) begin
         hit_ff <= dv_side.hit;
         pos_ff <= pos_in;
      end
   end

   assign rsp_if.valid = ov_ff;
   assign rsp_if.hit   = hit_ff;
   assign rsp_if.out_x = pos_ff[0];
   assign rsp_if.out_y = pos_ff[1];
   assign rsp_if.out_z = pos_ff[2];

   // A push is only ever requested for a pair that overlaps.
   a_push_needs_hit: assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_side.push |-> dv_side.hit)
      else $error("push flagged without a hit");

   // Cylinder pushes never move body B vertically.
   a_cyl_no_y: assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_side.cyl && dv_side.push |-> dv_off[1] == '0)
      else $error("cylinder push has a vertical offset");

   // The output stage comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

endmodule
